// ===== sv/qsort_pkg.sv =====
// ----------------------------------------------------------------------------
// qsort_pkg
// shared types and constants of the quicksort buffer sorter
// ----------------------------------------------------------------------------
`default_nettype none
package qsort_pkg;
    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int SP_W        = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        value_t value;
        logic   last;
    } in_beat_t;

    typedef struct packed {
        value_t sorted_value;
        logic   final_res;
        logic   overflow;
    } out_beat_t;
endpackage
`default_nettype wire

// ===== sv/qsort_if.sv =====
// ----------------------------------------------------------------------------
// qsort_if
// valid/ready channel carrying one beat
// ----------------------------------------------------------------------------
`default_nettype none
interface qsort_if #(parameter type beat_t = logic);
    logic  valid;
    logic  ready;
    beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/quicksort_buffer_sorter.sv =====
// ----------------------------------------------------------------------------
// quicksort_buffer_sorter
// buffers signed values and emits them sorted after the last beat
// ----------------------------------------------------------------------------
// loading: one beat per cycle, ready high only while collecting
// sort: pop a range, move its middle value to the front as pivot, partition; about N log N compares
// output: a store read, then the beat for each value, held while the sink is not ready
// one-value set: pop, middle, pop, store read, then its result; ready returns after the final beat
// reset: count, overflow flag and sequencer cleared; store contents undefined
`default_nettype none
module quicksort_buffer_sorter (
    input wire logic clk,
    input wire logic rst_n,
    qsort_if.sink    in_ch,
    qsort_if.source  out_ch
);
    import qsort_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_MID   = 4'd2;
    localparam logic [3:0] S_SWLM  = 4'd3;
    localparam logic [3:0] S_RDI   = 4'd4;
    localparam logic [3:0] S_CMPI  = 4'd5;
    localparam logic [3:0] S_CMPJ  = 4'd6;
    localparam logic [3:0] S_SWIJ  = 4'd7;
    localparam logic [3:0] S_RDC   = 4'd8;
    localparam logic [3:0] S_PUSH  = 4'd9;
    localparam logic [3:0] S_OUTRD = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_RDJ   = 4'd13;

    value_t mem [CAPACITY];
    logic [2*IDX_W-1:0] stk [CAPACITY];

    logic [3:0] state_reg;
    cnt_t       count_reg;
    logic       drop_reg;
    logic [SP_W-1:0] sp_reg;
    idx_t       l_reg, r_reg;
    logic [IDX_W:0] i_reg, j_reg;
    value_t     pv_reg, a_reg, b_reg;
    idx_t       k_reg;
    idx_t       wa_reg;

    wire logic in_fire  = in_ch.valid && in_ch.ready;
    wire logic out_fire = out_ch.valid && out_ch.ready;
    wire idx_t sp_idx   = sp_reg[IDX_W-1:0];
    assign in_ch.ready = (state_reg == S_LOAD);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data.sorted_value = a_reg;
    assign out_ch.data.final_res = ({1'b0, k_reg} == count_reg - cnt_t'(1));
    assign out_ch.data.overflow = drop_reg;

    // signed compares against the pivot
    wire logic le = (a_reg <= pv_reg);
    wire logic lej = (b_reg <= pv_reg);
    wire logic [IDX_W:0] cut = i_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_fire && count_reg < cnt_t'(CAPACITY))
            mem[count_reg[IDX_W-1:0]] <= in_ch.data.value;
        if (state_reg == S_SWLM)
        begin
            mem[l_reg] <= pv_reg;
            mem[wa_reg] <= a_reg;
        end
        if (state_reg == S_SWIJ)
        begin
            mem[i_reg[IDX_W-1:0]] <= b_reg;
            mem[j_reg[IDX_W-1:0]] <= a_reg;
        end
        if (state_reg == S_PUSH)
        begin
            mem[l_reg] <= a_reg;
            mem[cut[IDX_W-1:0]] <= pv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            sp_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (count_reg < cnt_t'(CAPACITY))
                            count_reg <= count_reg + cnt_t'(1);
                        else
                            drop_reg <= 1'b1;
                        if (in_ch.data.last)
                        begin
                            stk[0] <= {idx_t'(0), idx_t'(count_reg < cnt_t'(CAPACITY)
                                ? count_reg : count_reg - cnt_t'(1))};
                            sp_reg <= SP_W'(1);
                            state_reg <= S_POP;
                        end
                    end
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        k_reg <= '0;
                        state_reg <= (count_reg == '0) ? S_LOAD : S_OUTRD;
                    end
                    else
                    begin
                        sp_reg <= sp_reg - 1'b1;
                        {l_reg, r_reg} <= stk[sp_idx - 1'b1];
                        state_reg <= S_MID;
                    end
                end
                S_MID:
                begin
                    if (l_reg >= r_reg)
                        state_reg <= S_POP;
                    else
                    begin
                        wa_reg <= l_reg + ((r_reg - l_reg) >> 1);
                        pv_reg <= mem[l_reg + ((r_reg - l_reg) >> 1)];
                        a_reg  <= mem[l_reg];
                        state_reg <= S_SWLM;
                    end
                end
                S_SWLM:
                begin
                    i_reg <= {1'b0, l_reg} + 1'b1;
                    j_reg <= {1'b0, r_reg};
                    state_reg <= S_RDI;
                end
                S_RDI:
                begin
                    if (i_reg > j_reg)
                        state_reg <= S_RDC;
                    else
                    begin
                        a_reg <= mem[i_reg[IDX_W-1:0]];
                        state_reg <= S_CMPI;
                    end
                end
                S_CMPI:
                begin
                    if (le)
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_RDI;
                    end
                    else
                        state_reg <= S_RDJ;
                end
                S_RDJ:
                begin
                    if (i_reg > j_reg)
                        state_reg <= S_RDC;
                    else
                    begin
                        b_reg <= mem[j_reg[IDX_W-1:0]];
                        state_reg <= S_CMPJ;
                    end
                end
                S_CMPJ:
                begin
                    if (!lej)
                    begin
                        j_reg <= j_reg - 1'b1;
                        state_reg <= S_RDJ;
                    end
                    else
                        state_reg <= (i_reg < j_reg) ? S_SWIJ : S_RDC;
                end
                S_SWIJ:
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= j_reg - 1'b1;
                    state_reg <= S_RDI;
                end
                S_RDC:
                begin
                    a_reg <= mem[cut[IDX_W-1:0]];
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    if (cut > {1'b0, l_reg} + 1'b1 && cut < {1'b0, r_reg} - 1'b1
                        && {1'b0, r_reg} != '0)
                    begin
                        stk[sp_idx] <= {l_reg, idx_t'(cut - 1'b1)};
                        stk[sp_idx + 1'b1] <= {idx_t'(cut + 1'b1), r_reg};
                        sp_reg <= sp_reg + 2'd2;
                    end
                    else if (cut > {1'b0, l_reg} + 1'b1)
                    begin
                        stk[sp_idx] <= {l_reg, idx_t'(cut - 1'b1)};
                        sp_reg <= sp_reg + 1'b1;
                    end
                    else if ({1'b0, r_reg} > cut + 1'b1)
                    begin
                        stk[sp_idx] <= {idx_t'(cut + 1'b1), r_reg};
                        sp_reg <= sp_reg + 1'b1;
                    end
                    state_reg <= S_POP;
                end
                S_OUTRD:
                begin
                    a_reg <= mem[k_reg];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        if (out_ch.data.final_res)
                        begin
                            count_reg <= '0;
                            drop_reg <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_OUTRD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    a_no_in_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> !in_ch.ready) else $error("ready while busy");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(CAPACITY)) else $error("count over capacity");
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(CAPACITY)) else $error("stack overflow");
    a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> count_reg != '0) else $error("output with empty store");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the quicksort buffer sorter: sets of signed values are loaded over
// the input channel, a local sorter predicts each sorted run, and every
// output beat is compared in order with the expected run
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qsort_pkg::*;

    logic clk;
    logic rst_n;

    qsort_if #(.beat_t(in_beat_t))  in_ch ();
    qsort_if #(.beat_t(out_beat_t)) out_ch ();

    quicksort_buffer_sorter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    value_t    set_store[$];
    logic      set_dropped;
    out_beat_t sorted_q[$];
    int        mismatches;
    int        beats_sent;
    int        runs_sent;
    int        beats_checked;
    bit        src_idle_on;
    bit        sink_idle_on;
    int        sink_gap;

    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int idle_len(bit enable);
        if (!enable || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 6);
    endfunction

    // expected run once the last beat of a set arrives
    task automatic predict_sorted_run();
        value_t vals[$];
        value_t t;
        int     n;
        vals = set_store;
        n = vals.size();
        for (int a = 1; a < n; a++)
        begin
            t = vals[a];
            for (int b = a; b > 0 && vals[b-1] > t; b--)
            begin
                vals[b] = vals[b-1];
                vals[b-1] = t;
            end
        end
        for (int k = 0; k < n; k++)
            sorted_q.push_back('{sorted_value: vals[k], final_res: (k == n - 1),
                                 overflow: set_dropped});
        set_store.delete();
        set_dropped = 1'b0;
    endtask

    task automatic send_beat(value_t v, logic last);
        int gap;
        gap = idle_len(src_idle_on);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{value: v, last: last};
        do
            @(posedge clk);
        while (!in_ch.ready);
        beats_sent++;
        if (set_store.size() < CAPACITY)
            set_store.push_back(v);
        else
            set_dropped = 1'b1;
        if (last)
        begin
            runs_sent++;
            predict_sorted_run();
        end
    endtask

    task automatic send_set(int n, int mode);
        value_t v;
        for (int k = 0; k < n; k++)
        begin
            case (mode)
                0: v = $urandom;
                1: v = $urandom_range(0, 7) - 4;
                2: v = k;
                3: v = n - k;
                default: v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            endcase
            send_beat(v, k == n - 1);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_beat(32'sh7fffffff, 1'b1);
        send_beat(32'sh80000000, 1'b0);
        send_beat(32'sh7fffffff, 1'b0);
        send_beat(32'sh00000000, 1'b0);
        send_beat(-32'sd1, 1'b1);
        send_set(5, 1);
        send_set(4, 4);
        send_set(CAPACITY, 3);
    endtask

    task automatic test_overflow();
        send_set(CAPACITY + 3, 0);
        send_set(CAPACITY + 1, 1);
        // full store, last beat dropped
        send_set(CAPACITY + 1, 2);
    endtask

    task automatic test_random_sets();
        while (beats_sent < 180)
        begin
            send_set($urandom_range(0, 5) == 0 ? $urandom_range(CAPACITY - 2, CAPACITY + 2)
                                               : $urandom_range(1, 8),
                     $urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    task automatic test_full_rate();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int s = 0; s < 6; s++)
            send_set($urandom_range(1, CAPACITY), 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (sink_gap == 0)
                sink_gap = idle_len(sink_idle_on);
            if (sink_gap > 0)
            begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            beats_checked++;
            if (sorted_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value %0d final %0b overflow %0b",
                             out_ch.data.sorted_value, out_ch.data.final_res,
                             out_ch.data.overflow);
            end
            else
            begin
                want = sorted_q.pop_front();
                if (out_ch.data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 want.sorted_value, want.final_res, want.overflow,
                                 out_ch.data.sorted_value, out_ch.data.final_res,
                                 out_ch.data.overflow);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        set_dropped   = 1'b0;
        mismatches    = 0;
        beats_sent    = 0;
        runs_sent     = 0;
        beats_checked = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        wait_drained();
        test_random_sets();
        test_full_rate();
        wait_drained();
        repeat (50) @(posedge clk);
        if (set_store.size() != 0)
            mismatches++;
        $display("%0d input beats in %0d sets, %0d sorted beats checked",
                 beats_sent, runs_sent, beats_checked);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
